@@ hdl/itra_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the integer to radix ASCII unit.
// Used by itra_ctrl, itra_datapath and integer_to_radix_ascii_unit; depends on nothing.

package itra_pkg;

   localparam int RADIX_W = 6;
   localparam int CHAR_W = 8;
   localparam int DIV_BITS = 4;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 8'h57;
   localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
   localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMPTY,
      ST_DIV,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic rd;
      logic emit_sign;
      logic emit_digit;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic radix_ok;
      logic neg;
      logic step_last;
      logic quot_zero;
      logic stack_empty;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] digit);
      logic [CHAR_W-1:0] ext;
      ext = CHAR_W'(digit);
      if (digit < DECIMAL_DIGITS) begin
         return CHAR_ZERO + ext;
      end else begin
         return CHAR_ALPHA_BASE + ext;
      end
   endfunction

endpackage

@@ hdl/itra_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the integer to radix ASCII unit.
// Depends on itra_pkg; drives commands to itra_datapath and reads its status.

module itra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  itra_pkg::status_type status,
   output itra_pkg::cmd_type    cmd
);

   itra_pkg::state_type state_ff;
   itra_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         itra_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.radix_ok ? itra_pkg::ST_DIV : itra_pkg::ST_EMPTY;
            end
         end
         itra_pkg::ST_EMPTY: begin
            cmd.emit_empty = 1'b1;
            state_in = itra_pkg::ST_IDLE;
         end
         itra_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (status.step_last && status.quot_zero) begin
               state_in = status.neg ? itra_pkg::ST_SIGN : itra_pkg::ST_READ;
            end
         end
         itra_pkg::ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            cmd.rd = 1'b1;
            state_in = itra_pkg::ST_EMIT;
         end
         itra_pkg::ST_READ: begin
            cmd.rd = 1'b1;
            state_in = itra_pkg::ST_EMIT;
         end
         itra_pkg::ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            if (status.stack_empty) begin
               state_in = itra_pkg::ST_IDLE;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         default: begin
            state_in = itra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/itra_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the integer to radix ASCII unit: radix register, iterative divider,
// digit stack memory and result register. Depends on itra_pkg; driven by itra_ctrl.

module itra_datapath #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [itra_pkg::RADIX_W-1:0]   csr_write_data,
   input  logic [VALUE_BITS-1:0]          req_value,
   input  itra_pkg::cmd_type              cmd,
   output itra_pkg::status_type           status,
   output logic                           rsp_valid,
   output logic [itra_pkg::CHAR_W-1:0]    rsp_character,
   output logic                           rsp_last,
   output logic                           rsp_empty_res
);

   localparam int STEPS = (VALUE_BITS + itra_pkg::DIV_BITS - 1) / itra_pkg::DIV_BITS;
   localparam int PAD_W = STEPS * itra_pkg::DIV_BITS;
   localparam int STEP_W = $clog2(STEPS);
   localparam int ADDR_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int RW = itra_pkg::RADIX_W;

   logic [RW-1:0]             radix_ff;
   logic [PAD_W-1:0]          mag_ff;
   logic [RW-1:0]             rem_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      neg_ff;
   logic [RW-1:0]             rd_data_ff;
   logic [RW-1:0]             stack_mem [VALUE_BITS];
   logic                      rsp_valid_ff;
   logic [itra_pkg::CHAR_W-1:0] rsp_char_ff;
   logic                      rsp_last_ff;
   logic                      rsp_empty_ff;

   logic [VALUE_BITS-1:0]     in_mag;
   logic [PAD_W-1:0]          div_quot;
   logic [RW-1:0]             div_rem;
   logic [CNT_W-1:0]          count_dec;
   logic                      step_last;

   assign in_mag = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;
   assign count_dec = count_ff - CNT_W'(1);
   assign step_last = (step_ff == STEP_W'(STEPS - 1));

   // Restoring division, several quotient bits per cycle; the remainder stays below the radix.
   always_comb begin
      logic [RW:0] trial;
      logic        qbit;
      div_rem = rem_ff;
      div_quot = mag_ff;
      for (int k = 0; k < itra_pkg::DIV_BITS; k++) begin
         trial = {div_rem, div_quot[PAD_W-1]};
         if (trial >= {1'b0, radix_ff}) begin
            trial = trial - {1'b0, radix_ff};
            qbit = 1'b1;
         end else begin
            qbit = 1'b0;
         end
         div_rem = trial[RW-1:0];
         div_quot = {div_quot[PAD_W-2:0], qbit};
      end
   end

   always_comb begin
      status.radix_ok = (radix_ff >= itra_pkg::RADIX_MIN) && (radix_ff <= itra_pkg::RADIX_MAX);
      status.neg = neg_ff;
      status.step_last = step_last;
      status.quot_zero = (div_quot == '0);
      status.stack_empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itra_pkg::RADIX_RESET;
         step_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
         if (cmd.load) begin
            step_ff <= '0;
            count_ff <= '0;
         end else if (cmd.step) begin
            if (step_last) begin
               step_ff <= '0;
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end else if (cmd.rd) begin
            count_ff <= count_dec;
         end
         rsp_valid_ff <= cmd.emit_sign | cmd.emit_digit | cmd.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= PAD_W'(in_mag);
         rem_ff <= '0;
         neg_ff <= req_value[VALUE_BITS-1];
      end else if (cmd.step) begin
         mag_ff <= div_quot;
         rem_ff <= step_last ? '0 : div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && step_last) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= div_rem;
      end
      if (cmd.rd) begin
         rd_data_ff <= stack_mem[count_dec[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_empty) begin
         rsp_char_ff <= itra_pkg::CHAR_NONE;
         rsp_last_ff <= 1'b1;
         rsp_empty_ff <= 1'b1;
      end else if (cmd.emit_sign) begin
         rsp_char_ff <= itra_pkg::CHAR_MINUS;
         rsp_last_ff <= 1'b0;
         rsp_empty_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_ff <= itra_pkg::digit_char(rd_data_ff);
         rsp_last_ff <= (count_ff == '0);
         rsp_empty_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

@@ hdl/integer_to_radix_ascii_unit.sv @@
`timescale 1ns / 1ps
// Top level of the integer to radix ASCII unit: joins itra_ctrl and itra_datapath.
// Depends on itra_pkg, itra_ctrl and itra_datapath.
//
//   Channel   Ports                                          Handshake
//   request   req_value                                      start, busy
//   response  rsp_character, rsp_last, rsp_empty_res         rsp_valid (one cycle)
//   config    csr_write_data                                 csr_write_enable
//
// An item keeps busy high while it is divided and while its characters are read out.
// The divider produces four quotient bits per cycle, and the division is repeated for each digit;
// after that the digit stack memory delivers one character per cycle.
// An invalid radix gives a single empty result, set from ST_EMPTY through the response register.
// Reset restores the radix to ten and empties the block; results cannot be stalled.

module integer_to_radix_ascii_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [VALUE_BITS-1:0]          req_value,
   output logic                           rsp_valid,
   output logic [itra_pkg::CHAR_W-1:0]    rsp_character,
   output logic                           rsp_last,
   output logic                           rsp_empty_res,
   input  logic                           csr_write_enable,
   input  logic [itra_pkg::RADIX_W-1:0]   csr_write_data
);

   itra_pkg::cmd_type    cmd;
   itra_pkg::status_type status;

   itra_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   itra_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_result_in_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item at work");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> rsp_last)
      else $error("empty result not marked last");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy still high with final character");
`endif

endmodule

@@ tb/sv/integer_to_radix_ascii_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_radix_ascii_unit: converts integers to radix text
// and checks every character against its own prediction. Depends on itra_pkg and the unit.

module integer_to_radix_ascii_unit_tb;

   localparam int VALUE_W = 32;
   localparam int RANDOM_ITEMS = 105;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [itra_pkg::CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

   typedef struct {
      logic [itra_pkg::CHAR_W-1:0] code;
      logic is_last;
      logic is_empty;
   } text_char_type;

   class radix_text_scoreboard;
      logic [itra_pkg::RADIX_W-1:0] radix;
      text_char_type expected_chars[$];
      int failures;

      function new();
         radix = itra_pkg::RADIX_RESET;
         failures = 0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) begin
            $display("%0t: mismatch: %s", $realtime, msg);
         end
      endfunction

      function logic [itra_pkg::CHAR_W-1:0] digit_ascii(int unsigned d);
         if (d < 10) begin
            return itra_pkg::CHAR_ZERO + itra_pkg::CHAR_W'(d);
         end else begin
            return CHAR_LOWER_A + itra_pkg::CHAR_W'(d - 10);
         end
      endfunction

      function void note_value(logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] twos;
         longint unsigned magnitude;
         int unsigned base;
         logic [itra_pkg::CHAR_W-1:0] digits[$];
         text_char_type c;
         base = radix;
         if (radix < itra_pkg::RADIX_MIN || radix > itra_pkg::RADIX_MAX) begin
            c.code = itra_pkg::CHAR_NONE;
            c.is_last = 1'b1;
            c.is_empty = 1'b1;
            expected_chars.push_back(c);
            return;
         end
         twos = ~value + 1'b1;
         magnitude = value[VALUE_W-1] ? 64'(twos) : 64'(value);
         do begin
            digits.push_front(digit_ascii(int'(magnitude % base)));
            magnitude = magnitude / base;
         end while (magnitude != 0);
         c.is_empty = 1'b0;
         c.is_last = 1'b0;
         if (value[VALUE_W-1]) begin
            c.code = itra_pkg::CHAR_MINUS;
            expected_chars.push_back(c);
         end
         foreach (digits[i]) begin
            c.code = digits[i];
            c.is_last = (i == digits.size() - 1);
            expected_chars.push_back(c);
         end
      endfunction

      function void check_char(logic [itra_pkg::CHAR_W-1:0] code, logic is_last,
                               logic is_empty);
         text_char_type e;
         if (expected_chars.size() == 0) begin
            flag($sformatf("unexpected character %h last %b empty %b", code, is_last, is_empty));
            return;
         end
         e = expected_chars.pop_front();
         if (code !== e.code || is_last !== e.is_last || is_empty !== e.is_empty) begin
            flag($sformatf("expected char %h last %b empty %b, got char %h last %b empty %b",
                           e.code, e.is_last, e.is_empty, code, is_last, is_empty));
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function void close_out();
         if (expected_chars.size() != 0) begin
            flag($sformatf("%0d characters never arrived", expected_chars.size()));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic [itra_pkg::CHAR_W-1:0] rsp_character;
   logic rsp_last;
   logic rsp_empty_res;
   logic csr_write_enable = 1'b0;
   logic [itra_pkg::RADIX_W-1:0] csr_write_data = '0;

   int cycle_count = 0;
   int burst_left = 0;
   radix_text_scoreboard sb = new();

   integer_to_radix_ascii_unit #(
      .VALUE_BITS(VALUE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last),
      .rsp_empty_res(rsp_empty_res),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_value(req_value);
         end
         if (rsp_valid) begin
            sb.check_char(rsp_character, rsp_last, rsp_empty_res);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("integer_to_radix_ascii_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic send_value(input logic [VALUE_W-1:0] value, input int gap);
      req_value <= value;
      start <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   task automatic send_paced(input logic [VALUE_W-1:0] value, input bit closing);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(1, 9);
         burst_left = $urandom_range(0, 7);
      end
      if (closing && gap == 0) begin
         gap = 1;
      end
      send_value(value, gap);
   endtask

   task automatic drain();
      do @(negedge clock); while (sb.pending() > 0 || busy);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_radix(input logic [itra_pkg::RADIX_W-1:0] r);
      csr_write_data <= r;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.radix = r;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input logic [itra_pkg::RADIX_W-1:0] r);
      int kind;
      longint p;
      logic [VALUE_W-1:0] v;
      kind = $urandom_range(0, 5);
      case (kind)
         0: v = $urandom;
         1: v = $urandom_range(0, 100);
         2: begin
            p = 1;
            if (r >= itra_pkg::RADIX_MIN && r <= itra_pkg::RADIX_MAX) begin
               repeat ($urandom_range(1, 31)) begin
                  if (p * r < 64'sh8000_0000) begin
                     p = p * r;
                  end
               end
            end
            v = VALUE_W'(p - $urandom_range(0, 1));
         end
         3: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if (kind != 3 && $urandom_range(0, 1) == 1) begin
         v = ~v + 1'b1;
      end
      return v;
   endfunction

   function automatic logic [itra_pkg::RADIX_W-1:0] pick_radix();
      case ($urandom_range(0, 9))
         0: return itra_pkg::RADIX_MIN;
         1: return itra_pkg::RADIX_MAX;
         2: begin
            case ($urandom_range(0, 2))
               0: return 6'd0;
               1: return 6'd1;
               default: return itra_pkg::RADIX_W'($urandom_range(37, 63));
            endcase
         end
         default: return itra_pkg::RADIX_W'($urandom_range(2, 36));
      endcase
   endfunction

   initial begin
      int sent;
      int phase_len;
      logic [itra_pkg::RADIX_W-1:0] r;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset radix is ten.
      send_value(32'd0, 0);
      send_value(32'd1, 0);
      send_value(32'hffff_ffff, 2);
      send_value(32'd9, 0);
      send_value(32'd10, 1);
      send_value(32'h7fff_ffff, 0);
      send_value(32'h8000_0000, 3);
      send_value(32'd12345, 0);
      send_value(-32'sd987, 1);
      drain();

      set_radix(itra_pkg::RADIX_MIN);
      send_value(32'd0, 0);
      send_value(32'hffff_ffff, 0);
      send_value(32'h8000_0000, 2);
      send_value(32'h7fff_ffff, 0);
      send_value(32'd5, 1);
      drain();

      set_radix(itra_pkg::RADIX_MAX);
      send_value(32'd35, 0);
      send_value(32'd36, 1);
      send_value(-32'sd35, 0);
      send_value(32'h7fff_ffff, 0);
      send_value(32'h8000_0000, 0);
      send_value(32'd0, 1);
      drain();

      // Radix values outside two to thirty-six give a single empty item.
      set_radix(6'd0);
      send_value(32'd7, 0);
      send_value(-32'sd7, 1);
      drain();
      set_radix(6'd1);
      send_value(32'd0, 1);
      drain();
      set_radix(6'd37);
      send_value(32'd3, 1);
      drain();
      set_radix(6'd63);
      send_value(32'hffff_ffff, 1);
      drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = pick_radix();
         set_radix(r);
         phase_len = $urandom_range(6, 18);
         for (int i = 0; i < phase_len; i++) begin
            send_paced(pick_value(r), i == phase_len - 1);
            sent++;
         end
         drain();
      end

      sb.close_out();
      if (sb.failures == 0) begin
         $display("integer_to_radix_ascii_unit_tb: PASS");
      end else begin
         $display("integer_to_radix_ascii_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
